// ===== rtl/core/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
`default_nettype none
package wgm_pkg;

  localparam int MAX_MASK = 63;
  localparam int LEN_W    = $clog2(MAX_MASK + 1);

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_FINISH = 2'd2,
    OP_CLEAR  = 2'd3
  } wgm_op_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic       step;
    logic       restart;
    logic [7:0] text;
  } wgm_ctl_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } wgm_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wgm_cell.sv =====
// One mask position: stored byte, its active bit and the per-character step.
`default_nettype none
module wgm_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire wgm_pkg::wgm_ctl_t ctl,
  input  wire logic            start,
  input  wire logic            live,
  input  wire logic            wr_en,
  input  wire logic [7:0]      wr_char,
  input  wire logic            closed,
  input  wire logic            take_in,
  output logic                 active,
  output logic                 star,
  output logic                 take_out
);
  import wgm_pkg::*;

  logic [7:0] mask_char;
  logic       char_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_char <= wr_char;
    end
  end

  always_comb begin
    star     = live && (mask_char == STAR_CHAR);
    char_hit = live && !star && ((mask_char == ANY_CHAR) || (mask_char == ctl.text));
    take_out = closed && char_hit;
  end

  // A star keeps its own position; a literal hands the beat to the next cell.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      active <= start;
    end else if (ctl.step) begin
      active <= (closed && star) || take_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wgm_out_buf.sv =====
// Two-entry result buffer: output register plus skid slot.
`default_nettype none
module wgm_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire wgm_pkg::wgm_result_t push_data,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wgm_pkg::wgm_result_t      out_data
);
  import wgm_pkg::*;

  wgm_result_t skid_data;
  logic        skid_valid;
  logic        pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop && skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (push && out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else if (push) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wildcard_glob_matcher_core.sv =====
// Top level of the wildcard glob matcher: cell row, star closure, control.
// Usage:
//   Input channel (in_valid/in_ready, op, character) takes one beat per
//   cycle while in_ready is high. op APPEND adds a mask byte, TEXT advances
//   the match by one text byte, FINISH reports and restarts the text, CLEAR
//   empties the mask. '*' matches any run, '?' one byte; all else matches itself.
//   Bytes beyond 63 mask positions are dropped and flag overflow.
//   Only FINISH makes a result beat (out_valid/out_ready, matched,
//   mask_overflow), registered and held in the output buffer until taken.
//   Throughput is one beat per cycle while in_ready is high; every mask cell
//   updates in parallel, and the star closure is one carry chain across the
//   row, so a text byte is fully absorbed in the cycle it is accepted.
//   A two-entry output buffer lets input continue while a result waits;
//   in_ready drops only when both entries hold results.
//   Reset (synchronous) empties the mask, clears overflow, restarts the
//   match and drops any pending results; stored mask bytes are not cleared.
`default_nettype none
module wildcard_glob_matcher_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] op,
  input  wire logic [7:0] character,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            matched,
  output logic            mask_overflow
);
  import wgm_pkg::*;

  localparam int VW = MAX_MASK + 1;

  logic [LEN_W-1:0] mask_len;
  logic             ovf;
  logic             tail_active;

  logic [VW-1:0] act, stars, gen, carries, closed;
  logic [MAX_MASK:0] take;
  logic [MAX_MASK-1:0] live, wr_en;

  logic        accept, buf_full, push;
  wgm_ctl_t    ctl;
  wgm_result_t res, out_res;
  wgm_op_t     op_code;

  assign op_code  = wgm_op_t'(op);
  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl.step    = 1'b0;
    ctl.restart = 1'b0;
    ctl.text    = character;
    push        = 1'b0;
    if (accept) begin
      unique case (op_code)
        OP_APPEND: ;
        OP_TEXT:   ctl.step = 1'b1;
        OP_FINISH: begin
          push        = 1'b1;
          ctl.restart = 1'b1;
        end
        OP_CLEAR:  ctl.restart = 1'b1;
        default:   ;
      endcase
    end
  end

  assign take[0] = 1'b0;

  for (genvar i = 0; i < MAX_MASK; i++) begin : g_cell
    assign live[i]  = mask_len > LEN_W'(i);
    assign wr_en[i] = accept && (op_code == OP_APPEND) && (mask_len == LEN_W'(i));

    wgm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .start    (i == 0),
      .live     (live[i]),
      .wr_en    (wr_en[i]),
      .wr_char  (character),
      .closed   (closed[i]),
      .take_in  (take[i]),
      .active   (act[i]),
      .star     (stars[i]),
      .take_out (take[i+1])
    );
  end

  assign act[MAX_MASK]   = tail_active;
  assign stars[MAX_MASK] = 1'b0;

  // Star closure as a carry chain: an active star generates, a star propagates.
  always_comb begin
    gen     = act & stars;
    carries = (stars + gen) ^ stars ^ gen;
    closed  = act | carries;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      tail_active <= 1'b0;
    end else if (ctl.step) begin
      tail_active <= take[MAX_MASK];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_len <= '0;
      ovf      <= 1'b0;
    end else if (accept && (op_code == OP_CLEAR)) begin
      mask_len <= '0;
      ovf      <= 1'b0;
    end else if (accept && (op_code == OP_APPEND)) begin
      if (mask_len == LEN_W'(MAX_MASK)) begin
        ovf <= 1'b1;
      end else begin
        mask_len <= mask_len + LEN_W'(1);
      end
    end
  end

  assign res.matched  = closed[mask_len] && !ovf;
  assign res.overflow = ovf;

  wgm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign matched       = out_res.matched;
  assign mask_overflow = out_res.overflow;

endmodule
`default_nettype wire
